// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/rsas_pkg.sv =====
// ---------------------------------------------------------------------------
// rsas_pkg
// shared widths for the rotated sorted array search block
// ---------------------------------------------------------------------------
package rsas_pkg;

  localparam int DATA_W = 32;  // element and target width
  localparam int POS_W  = 10;  // reported index width

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

endpackage

// ===== rtl/rsas_ram.sv =====
// ---------------------------------------------------------------------------
// rsas_ram
// element store: one write port, two read ports, registered read data
// ---------------------------------------------------------------------------
module rsas_ram
  import rsas_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/rotated_sorted_array_search.sv =====
// ---------------------------------------------------------------------------
// rotated_sorted_array_search
// stores a rotated ascending run of signed elements and binary-searches it
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start && !busy       action, value, restart
//  result    done (one cycle)     found, position
//
//  a load is taken while busy stays low; it gives no result
//  a search on n elements probes k <= ceil(log2(n+1)) times; each probe is a
//  memory read state (ST_PROBE) followed by a compare state (ST_CMP), after
//  the state that captures the last element (ST_LAST); a search of an empty
//  array strobes done the next cycle
//  rst is synchronous; it empties the array and idles the search sequencer
//  the result port cannot be stalled: done is high for exactly one cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rotated_sorted_array_search
  import rsas_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     restart,
  output logic                     done,
  output logic                     found,
  output logic [POS_W-1:0]         position
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_PROBE,
    ST_CMP
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic signed [IW-1:0]     lo;
  logic signed [IW-1:0]     hi;
  logic [CW-1:0]            mid_r;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] last;

  logic                     accept;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr_a;
  logic [AW-1:0]            raddr_b;
  logic signed [DATA_W-1:0] rdata_a;
  logic signed [DATA_W-1:0] rdata_b;
  logic [CW-1:0]            count_m1;
  logic [IW:0]              sum;
  logic [CW-1:0]            mid;
  logic signed [IW-1:0]     mid_s;
  logic signed [IW-1:0]     one_s;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign count_m1 = count - CW'(1);
  assign one_s    = IW'(1);

  // lo and hi are non-negative whenever lo <= hi, so the halved sum is the midpoint
  assign sum   = {lo[IW-1], lo} + {hi[IW-1], hi};
  assign mid   = sum[CW:1];
  assign mid_s = $signed({1'b0, mid_r});

  // a restart load always lands on element zero
  assign we    = accept && (action == ACT_LOAD) && (restart || (count < CW'(DEPTH)));
  assign waddr = restart ? '0 : count[AW-1:0];

  always_comb begin
    raddr_a = count_m1[AW-1:0];
    raddr_b = '0;
    case (state)
      ST_PROBE: begin
        raddr_a = mid[AW-1:0];
        raddr_b = lo[AW-1:0];
      end
      default: begin
        raddr_a = count_m1[AW-1:0];
        raddr_b = '0;
      end
    endcase
  end

  rsas_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      found    <= 1'b0;
      position <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_LOAD) begin
              if (restart) begin
                count <= CW'(1);
              end else if (count < CW'(DEPTH)) begin
                count <= count + CW'(1);
              end
            end else if (count == '0) begin
              done     <= 1'b1;
              found    <= 1'b0;
              position <= '0;
            end else begin
              target <= value;
              lo     <= '0;
              hi     <= $signed({1'b0, count}) - one_s;
              state  <= ST_LAST;
            end
          end
        end
        ST_LAST: begin
          // the last element read in the accept cycle arrives here
          last  <= rdata_a;
          state <= ST_PROBE;
        end
        ST_PROBE: begin
          if (lo > hi) begin
            done     <= 1'b1;
            found    <= 1'b0;
            position <= '0;
            state    <= ST_IDLE;
          end else begin
            mid_r <= mid;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          // rdata_a is the mid element, rdata_b the lo element
          if (rdata_a < target) begin
            if ((rdata_a < rdata_b) && (target > last)) begin
              hi <= mid_s - one_s;
            end else begin
              lo <= mid_s + one_s;
            end
            state <= ST_PROBE;
          end else if (rdata_a > target) begin
            if ((rdata_a > last) && (last >= target)) begin
              lo <= mid_s + one_s;
            end else begin
              hi <= mid_s - one_s;
            end
            state <= ST_PROBE;
          end else begin
            done     <= 1'b1;
            found    <= 1'b1;
            position <= POS_W'(mid_r);
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_done_idle, clk, rst, !done || !busy, "result strobed while search still running")
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(DEPTH), "element count beyond depth")
  `ASSERT_ALWAYS(a_probe_bound, clk, rst, (state != ST_CMP) || (mid_r < count), "probe outside held elements")
  `ASSERT_NEXT(a_probe_step, clk, rst, state == ST_PROBE, (state == ST_CMP) || (state == ST_IDLE), "probe not followed by compare or finish")

endmodule
